// ----- src/gdn_pkg.sv -----
// Shared types, constants and arithmetic helpers for the day number converter.
`timescale 1ns / 1ps

package gdn_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DN_W    = 22;

  // pipeline depth, input to result strobe
  localparam int LAT     = 9;
  localparam int FWD_STG = 5;
  localparam int FWD_PAD = LAT - FWD_STG;

  localparam logic [DN_W-1:0] MIN_DN_RST = 22'd584328;
  localparam logic [24:0]     DN_MAX     = 25'd4194303;

  // floor(y / 100) for y < 2^14: (y * R) >> 21
  localparam int          D100_SHIFT = 21;
  localparam logic [14:0] D100_RECIP = 15'(((1 << D100_SHIFT) + 99) / 100);

  // floor(v / 10) for v < 2^14: (v * R) >> 18
  localparam int          D10_SHIFT = 18;
  localparam logic [14:0] D10_RECIP = 15'(((1 << D10_SHIFT) + 9) / 10);

  // reverse year estimate: floor((400*d + 591) / 146097), reciprocal plus one correction
  localparam logic [30:0] Y_DIV       = 31'd146097;
  localparam int          Y_SHIFT     = 40;
  localparam logic [22:0] Y_RECIP     = 23'((64'd1 << Y_SHIFT) / 64'd146097);

  // floor(n / 3060) for n < 2^17: (n * R) >> 29
  localparam int          MI_SHIFT = 29;
  localparam logic [17:0] MI_RECIP = 18'(((64'd1 << MI_SHIFT) + 64'd3059) / 64'd3060);

  typedef enum logic {
    REQ_FWD = 1'b0,
    REQ_REV = 1'b1
  } req_e;

  typedef struct packed {
    logic [DN_W-1:0] day_number;
    logic            below_min;
  } fwd_res_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } rev_res_t;

  function automatic logic [7:0] div100(input logic [13:0] y);
    logic [28:0] prod;
    prod = 29'(y) * 29'(D100_RECIP);
    return prod[28:21];
  endfunction

  // days from March 1 to the first day of month index mi: (mi*306 + 5) / 10
  function automatic logic [9:0] month_offset(input logic [5:0] mi);
    logic [13:0] lin;
    logic [28:0] prod;
    lin  = 14'(mi) * 14'd306 + 14'd5;
    prod = 29'(lin) * 29'(D10_RECIP);
    return prod[27:18];
  endfunction

  // y*365 + y/4 - y/100 + y/400 for y >= 0, with q = y/100
  function automatic logic [22:0] days_before_year(input logic [13:0] y,
                                                   input logic [7:0]  q);
    return 23'(y) * 23'd365 + 23'(y[13:2]) - 23'(q) + 23'(q[7:2]);
  endfunction

endpackage

// ----- src/gdn_fwd.sv -----
// Date to day number pipeline, padded to the common latency.
`timescale 1ns / 1ps

module gdn_fwd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [gdn_pkg::YEAR_W-1:0]    year_i,
  input  logic [gdn_pkg::MONTH_W-1:0]   month_i,
  input  logic [gdn_pkg::DAY_W-1:0]     day_i,
  input  logic [gdn_pkg::DN_W-1:0]      min_dn_i,
  output logic                          vld_o,
  output gdn_pkg::fwd_res_t             res_o
);

  logic [gdn_pkg::FWD_STG-1:0] vld_q;

  // stage 1: fold month to a March-based index
  logic [4:0]  mon9;
  logic [3:0]  m_d;
  logic        borrow;
  logic [3:0]  m1_q;
  logic [13:0] y1_q;
  logic        neg1_q;
  logic [4:0]  day1_q;

  assign mon9   = 5'(month_i) + 5'd9;
  assign m_d    = (mon9 >= 5'd24) ? 4'(mon9 - 5'd24) :
                  (mon9 >= 5'd12) ? 4'(mon9 - 5'd12) : mon9[3:0];
  assign borrow = (m_d >= 4'd10);

  // stage 2
  logic [13:0] y2_q;
  logic [7:0]  q2_q;
  logic [9:0]  mt2_q;
  logic        neg2_q;
  logic [4:0]  day2_q;

  // stage 3
  logic signed [24:0] dby3_q;
  logic [9:0]         mt3_q;
  logic [4:0]         day3_q;

  // stage 4
  logic signed [24:0] dn4_q;

  // stage 5
  gdn_pkg::fwd_res_t res5_d, res5_q;

  always_comb begin
    res5_d.below_min = (dn4_q < $signed({3'b000, min_dn_i}));
    if (dn4_q < 25'sd0) begin
      res5_d.day_number = '0;
    end else if (dn4_q > $signed(gdn_pkg::DN_MAX)) begin
      res5_d.day_number = '1;
    end else begin
      res5_d.day_number = dn4_q[21:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[gdn_pkg::FWD_STG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= m_d;
    y1_q   <= year_i - 14'(borrow);
    neg1_q <= borrow && (year_i == '0);
    day1_q <= day_i;

    y2_q   <= y1_q;
    q2_q   <= gdn_pkg::div100(y1_q);
    mt2_q  <= gdn_pkg::month_offset({2'b00, m1_q});
    neg2_q <= neg1_q;
    day2_q <= day1_q;

    dby3_q <= neg2_q ? -25'sd365
                     : $signed({2'b00, gdn_pkg::days_before_year(y2_q, q2_q)});
    mt3_q  <= mt2_q;
    day3_q <= day2_q;

    dn4_q  <= dby3_q + $signed({15'd0, mt3_q}) + $signed({20'd0, day3_q}) - 25'sd1;

    res5_q <= res5_d;
  end

  // delay line to match the reverse pipeline
  gdn_pkg::fwd_res_t          pad_q     [gdn_pkg::FWD_PAD];
  logic [gdn_pkg::FWD_PAD-1:0] pad_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_vld_q <= '0;
    end else begin
      pad_vld_q <= {pad_vld_q[gdn_pkg::FWD_PAD-2:0], vld_q[gdn_pkg::FWD_STG-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q[0] <= res5_q;
    for (int i = 1; i < gdn_pkg::FWD_PAD; i++) begin
      pad_q[i] <= pad_q[i-1];
    end
  end

  assign vld_o = pad_vld_q[gdn_pkg::FWD_PAD-1];
  assign res_o = pad_q[gdn_pkg::FWD_PAD-1];

endmodule

// ----- src/gdn_rev.sv -----
// Day number to date pipeline: year estimate, correction, month and day split.
`timescale 1ns / 1ps

module gdn_rev (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic [gdn_pkg::DN_W-1:0] day_number_i,
  output logic                     vld_o,
  output gdn_pkg::rev_res_t        res_o
);

  logic [gdn_pkg::LAT-1:0] vld_q;

  logic [30:0] x1_q, x2_q, x3_q;
  logic [21:0] d1_q, d2_q, d3_q, d4_q, d5_q;
  logic [53:0] prod2_q;
  logic [13:0] q0_3_q;
  logic [30:0] qd3_q;
  logic [13:0] y4_q, y5_q, y6_q, yy7_q, yy8_q;
  logic [7:0]  qa5_q, qb5_q;
  logic signed [23:0] la6_q, lb6_q;
  logic [9:0]  left7_q, left8_q;
  logic [16:0] num7_q;
  logic [5:0]  mi8_q;

  logic [13:0] q0_d;
  logic [30:0] r4_d;
  logic [13:0] y4_d;
  logic        neg7_d;
  logic [9:0]  left7_d;
  logic [34:0] mi_prod;

  assign q0_d    = prod2_q[53:40];
  assign r4_d    = x3_q - qd3_q;
  assign y4_d    = (r4_d >= gdn_pkg::Y_DIV) ? q0_3_q + 14'd1 : q0_3_q;
  assign neg7_d  = la6_q[23];
  assign left7_d = neg7_d ? lb6_q[9:0] : la6_q[9:0];
  assign mi_prod = 35'(num7_q) * 35'(gdn_pkg::MI_RECIP);

  // final stage: month index to month, year carry and day
  logic [5:0]  t9;
  logic [1:0]  yq9;
  logic [5:0]  mo9;
  logic [10:0] dd9;
  gdn_pkg::rev_res_t res9_d, res9_q;

  always_comb begin
    t9 = mi8_q + 6'd2;
    if (t9 >= 6'd24) begin
      yq9 = 2'd2;
      mo9 = t9 - 6'd24;
    end else if (t9 >= 6'd12) begin
      yq9 = 2'd1;
      mo9 = t9 - 6'd12;
    end else begin
      yq9 = 2'd0;
      mo9 = t9;
    end
    dd9          = 11'(left8_q) + 11'd1 - 11'(gdn_pkg::month_offset(mi8_q));
    res9_d.year  = yy8_q + 14'(yq9);
    res9_d.month = 4'(mo9 + 6'd1);
    res9_d.day   = dd9[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[gdn_pkg::LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= 31'(day_number_i) * 31'd400 + 31'd591;
    d1_q    <= day_number_i;

    prod2_q <= 54'(x1_q) * 54'(gdn_pkg::Y_RECIP);
    x2_q    <= x1_q;
    d2_q    <= d1_q;

    q0_3_q  <= q0_d;
    qd3_q   <= 31'(q0_d) * gdn_pkg::Y_DIV;
    x3_q    <= x2_q;
    d3_q    <= d2_q;

    y4_q    <= y4_d;
    d4_q    <= d3_q;

    qa5_q   <= gdn_pkg::div100(y4_q);
    qb5_q   <= gdn_pkg::div100(y4_q - 14'd1);
    y5_q    <= y4_q;
    d5_q    <= d4_q;

    la6_q   <= $signed({2'b00, d5_q})
             - $signed({1'b0, gdn_pkg::days_before_year(y5_q, qa5_q)});
    lb6_q   <= $signed({2'b00, d5_q})
             - $signed({1'b0, gdn_pkg::days_before_year(y5_q - 14'd1, qb5_q)});
    y6_q    <= y5_q;

    left7_q <= left7_d;
    num7_q  <= 17'(left7_d) * 17'd100 + 17'd52;
    yy7_q   <= neg7_d ? y6_q - 14'd1 : y6_q;

    mi8_q   <= mi_prod[34:29];
    left8_q <= left7_q;
    yy8_q   <= yy7_q;

    res9_q  <= res9_d;
  end

  assign vld_o = vld_q[gdn_pkg::LAT-1];
  assign res_o = res9_q;

endmodule

// ----- src/gregorian_day_number_converter.sv -----
// Top level: Gregorian date / day number converter, forward and reverse pipelines.
//
//   channel   handshake                  payload
//   request   start_i (taken when !busy_o) req_type_i, year_in_i, month_in_i, day_in_i,
//                                        day_number_in_i
//   result    done_o, one-cycle strobe   day_number_out_o, year_out_o, month_out_o,
//                                        day_out_o, below_min_o
//   config    cfg_we_i                   cfg_wdata_i (min_day_number)
//
// One transaction per cycle; every result appears after the same latency from its request.
// Latency is set by the reverse path: year estimate multiply, correction multiply,
// two days-before-year evaluations, month index multiply.
// busy_o stays low; results leave in request order and are never held.
// Reset clears all valid bits and loads min_day_number with 584328 (1600-01-01).
`timescale 1ns / 1ps

module gregorian_day_number_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        req_type_i,
  input  logic [gdn_pkg::YEAR_W-1:0]  year_in_i,
  input  logic [gdn_pkg::MONTH_W-1:0] month_in_i,
  input  logic [gdn_pkg::DAY_W-1:0]   day_in_i,
  input  logic [gdn_pkg::DN_W-1:0]    day_number_in_i,
  input  logic                        cfg_we_i,
  input  logic [gdn_pkg::DN_W-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic [gdn_pkg::DN_W-1:0]    day_number_out_o,
  output logic [gdn_pkg::YEAR_W-1:0]  year_out_o,
  output logic [gdn_pkg::MONTH_W-1:0] month_out_o,
  output logic [gdn_pkg::DAY_W-1:0]   day_out_o,
  output logic                        below_min_o
);

  logic                    accept;
  logic [gdn_pkg::DN_W-1:0] min_dn_q;
  logic                    fwd_vld, rev_vld;
  gdn_pkg::fwd_res_t       fwd_res;
  gdn_pkg::rev_res_t       rev_res;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dn_q <= gdn_pkg::MIN_DN_RST;
    end else if (cfg_we_i) begin
      min_dn_q <= cfg_wdata_i;
    end
  end

  gdn_fwd u_fwd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (accept && (gdn_pkg::req_e'(req_type_i) == gdn_pkg::REQ_FWD)),
    .year_i   (year_in_i),
    .month_i  (month_in_i),
    .day_i    (day_in_i),
    .min_dn_i (min_dn_q),
    .vld_o    (fwd_vld),
    .res_o    (fwd_res)
  );

  gdn_rev u_rev (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (accept && (gdn_pkg::req_e'(req_type_i) == gdn_pkg::REQ_REV)),
    .day_number_i (day_number_in_i),
    .vld_o        (rev_vld),
    .res_o        (rev_res)
  );

  assign done_o           = fwd_vld || rev_vld;
  assign day_number_out_o = fwd_vld ? fwd_res.day_number : '0;
  assign below_min_o      = fwd_vld && fwd_res.below_min;
  assign year_out_o       = rev_vld ? rev_res.year : '0;
  assign month_out_o      = rev_vld ? rev_res.month : '0;
  assign day_out_o        = rev_vld ? rev_res.day : '0;

`ifndef SYNTHESIS
  a_one_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({fwd_vld, rev_vld}))
    else $error("forward and reverse results collide");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, gdn_pkg::LAT))
    else $error("result without a matching transaction");

  a_below_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    below_min_o |-> (done_o && (month_out_o == '0) && (year_out_o == '0)))
    else $error("below_min on a reverse result");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev_vld |-> ((month_out_o != '0) && (month_out_o <= 4'd12)))
    else $error("reverse month out of range");
`endif

endmodule

// ----- dv/gregorian_day_number_converter_test.sv -----
// Self-checking testbench for the Gregorian day number converter: directed and random requests.
`timescale 1ns / 1ps

module gregorian_day_number_converter_test;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  PHASE_ITEMS = 350;
  localparam longint DN_TOP   = 3652364;

  typedef struct packed {
    gdn_pkg::req_e                kind;
    logic [gdn_pkg::YEAR_W-1:0]  year;
    logic [gdn_pkg::MONTH_W-1:0] month;
    logic [gdn_pkg::DAY_W-1:0]   day;
    logic [gdn_pkg::DN_W-1:0]    day_number;
    logic                        drain_first;
  } conv_req_t;

  typedef struct packed {
    logic [gdn_pkg::DN_W-1:0]    day_number;
    logic [gdn_pkg::YEAR_W-1:0]  year;
    logic [gdn_pkg::MONTH_W-1:0] month;
    logic [gdn_pkg::DAY_W-1:0]   day;
    logic                        below_min;
  } conv_result_t;

  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        start_i         = 1'b0;
  logic                        req_type_i      = 1'b0;
  logic [gdn_pkg::YEAR_W-1:0]  year_in_i       = '0;
  logic [gdn_pkg::MONTH_W-1:0] month_in_i      = '0;
  logic [gdn_pkg::DAY_W-1:0]   day_in_i        = '0;
  logic [gdn_pkg::DN_W-1:0]    day_number_in_i = '0;
  logic                        cfg_we_i        = 1'b0;
  logic [gdn_pkg::DN_W-1:0]    cfg_wdata_i     = '0;
  logic                        busy_o;
  logic                        done_o;
  logic [gdn_pkg::DN_W-1:0]    day_number_out_o;
  logic [gdn_pkg::YEAR_W-1:0]  year_out_o;
  logic [gdn_pkg::MONTH_W-1:0] month_out_o;
  logic [gdn_pkg::DAY_W-1:0]   day_out_o;
  logic                        below_min_o;

  conv_req_t    pending_reqs[$];
  conv_result_t awaited_results[$];
  conv_req_t    on_port;

  logic [gdn_pkg::DN_W-1:0] min_day_cfg = gdn_pkg::MIN_DN_RST;
  int send_idle_pct = 14;
  int mismatches    = 0;
  int results_seen  = 0;
  int fwd_count     = 0;
  int rev_count     = 0;
  int below_count   = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  gregorian_day_number_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .year_in_i       (year_in_i),
    .month_in_i      (month_in_i),
    .day_in_i        (day_in_i),
    .day_number_in_i (day_number_in_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .day_number_out_o(day_number_out_o),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .below_min_o     (below_min_o)
  );

  always #5 clk_i = ~clk_i;

  // days from 0000-03-01 to March 1 of counting year y; division truncates toward zero
  function automatic longint year_start_day(input longint y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic conv_result_t convert_request(input conv_req_t rq);
    conv_result_t r;
    longint yr, mo, dy, m, y, dn, d, left, mi, t;
    r = '0;
    if (rq.kind == gdn_pkg::REQ_FWD) begin
      yr = longint'(rq.year);
      mo = longint'(rq.month);
      dy = longint'(rq.day);
      m  = (mo + 9) % 12;
      y  = yr - m / 10;
      dn = year_start_day(y) + (m * 306 + 5) / 10 + (dy - 1);
      if (dn < 0) r.day_number = '0;
      else if (dn > 4194303) r.day_number = '1;
      else r.day_number = dn[gdn_pkg::DN_W-1:0];
      r.below_min = (dn < longint'(min_day_cfg));
    end else begin
      d    = longint'(rq.day_number);
      y    = (10000 * d + 14780) / 3652425;
      left = d - year_start_day(y);
      if (left < 0) begin
        y    = y - 1;
        left = d - year_start_day(y);
      end
      mi = (52 + 100 * left) / 3060;
      t  = y + (mi + 2) / 12;
      r.year = t[gdn_pkg::YEAR_W-1:0];
      t  = (mi + 2) % 12 + 1;
      r.month = t[gdn_pkg::MONTH_W-1:0];
      t  = left - (mi * 306 + 5) / 10 + 1;
      r.day = t[gdn_pkg::DAY_W-1:0];
    end
    return r;
  endfunction

  function automatic conv_req_t noise_request();
    conv_req_t rq;
    rq.kind        = $urandom_range(0, 1) ? gdn_pkg::REQ_REV : gdn_pkg::REQ_FWD;
    rq.year        = 14'($urandom_range(0, 16383));
    rq.month       = 4'($urandom_range(0, 15));
    rq.day         = 5'($urandom_range(0, 31));
    rq.day_number  = 22'($urandom_range(0, 4194303));
    rq.drain_first = 1'b0;
    return rq;
  endfunction

  function automatic conv_req_t fwd_req(input int y, input int m, input int d);
    conv_req_t rq;
    rq       = noise_request();
    rq.kind  = gdn_pkg::REQ_FWD;
    rq.year  = y[gdn_pkg::YEAR_W-1:0];
    rq.month = m[gdn_pkg::MONTH_W-1:0];
    rq.day   = d[gdn_pkg::DAY_W-1:0];
    return rq;
  endfunction

  function automatic conv_req_t rev_req(input longint dn);
    conv_req_t rq;
    rq            = noise_request();
    rq.kind       = gdn_pkg::REQ_REV;
    rq.day_number = dn[gdn_pkg::DN_W-1:0];
    return rq;
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t    rq;
    conv_result_t date;
    longint       target;
    int           sel;
    rq  = noise_request();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      rq.kind  = gdn_pkg::REQ_FWD;
      rq.year  = 14'($urandom_range(1, 9999));
      rq.month = 4'($urandom_range(1, 12));
      rq.day   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31))
                                             : 5'($urandom_range(1, 28));
    end else if (sel < 45) begin
      // valid dates right around the configured minimum
      target = longint'(min_day_cfg) + longint'($urandom_range(0, 6)) - 3;
      if (target < 0) target = 0;
      if (target > DN_TOP) target = DN_TOP - longint'($urandom_range(0, 3));
      date     = convert_request(rev_req(target));
      rq.kind  = gdn_pkg::REQ_FWD;
      rq.year  = date.year;
      rq.month = date.month;
      rq.day   = date.day;
    end else if (sel < 55) begin
      rq.kind = gdn_pkg::REQ_FWD;
    end else if (sel < 80) begin
      rq.kind       = gdn_pkg::REQ_REV;
      rq.day_number = 22'($urandom_range(0, 32'(DN_TOP)));
    end else if (sel < 92) begin
      // March 1 or January 1 of a random year, give or take two days
      target = year_start_day(longint'($urandom_range(0, 9999)))
             + ($urandom_range(0, 1) ? 306 : 0) + longint'($urandom_range(0, 4)) - 2;
      if (target < 0) target = 0;
      if (target > DN_TOP) target = DN_TOP;
      rq.kind       = gdn_pkg::REQ_REV;
      rq.day_number = target[gdn_pkg::DN_W-1:0];
    end else begin
      rq.kind = gdn_pkg::REQ_REV;
    end
    rq.drain_first = ($urandom_range(0, 149) == 0);
    return rq;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || awaited_results.size() != 0 || start_i)
      @(posedge clk_i);
    repeat (gdn_pkg::LAT + 2) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [gdn_pkg::DN_W-1:0] cfg_val, input int idle_pct);
    send_idle_pct = idle_pct;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cfg_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    min_day_cfg  = cfg_val;
    cfg_writes++;
    repeat (PHASE_ITEMS) pending_reqs.push_back(random_request());
    wait_drained();
  endtask

  // driver
  always @(posedge clk_i) begin
    conv_req_t    nxt;
    conv_result_t res;
    logic         taken;
    taken = start_i && !busy_o;
    if (taken) begin
      res = convert_request(on_port);
      awaited_results.push_back(res);
      if (on_port.kind == gdn_pkg::REQ_FWD) fwd_count++;
      else rev_count++;
      if (res.below_min) below_count++;
    end
    if (!rst_ni || (start_i && !taken)) begin
      // keep current transaction on the port
    end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                 !(pending_reqs[0].drain_first && awaited_results.size() != 0)) begin
      nxt             = pending_reqs.pop_front();
      on_port         = nxt;
      start_i         <= 1'b1;
      req_type_i      <= nxt.kind;
      year_in_i       <= nxt.year;
      month_in_i      <= nxt.month;
      day_in_i        <= nxt.day;
      day_number_in_i <= nxt.day_number;
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (day_number_out_o !== want.day_number) begin
          $error("day_number_out: expected %0d, got %0d", want.day_number, day_number_out_o);
          mismatches++;
        end
        if (year_out_o !== want.year) begin
          $error("year_out: expected %0d, got %0d", want.year, year_out_o);
          mismatches++;
        end
        if (month_out_o !== want.month) begin
          $error("month_out: expected %0d, got %0d", want.month, month_out_o);
          mismatches++;
        end
        if (day_out_o !== want.day) begin
          $error("day_out: expected %0d, got %0d", want.day, day_out_o);
          mismatches++;
        end
        if (below_min_o !== want.below_min) begin
          $error("below_min: expected %0d, got %0d", want.below_min, below_min_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    conv_req_t rq;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset value of the minimum
    send_idle_pct = 14;
    pending_reqs.push_back(fwd_req(1600, 1, 1));
    pending_reqs.push_back(fwd_req(1599, 12, 31));
    pending_reqs.push_back(fwd_req(1, 1, 1));
    pending_reqs.push_back(fwd_req(9999, 12, 31));
    pending_reqs.push_back(fwd_req(0, 1, 1));
    pending_reqs.push_back(fwd_req(0, 2, 29));
    pending_reqs.push_back(fwd_req(0, 3, 1));
    pending_reqs.push_back(fwd_req(16383, 15, 31));
    pending_reqs.push_back(fwd_req(2024, 0, 15));
    rq = fwd_req(2023, 13, 1);
    rq.drain_first = 1'b1;
    pending_reqs.push_back(rq);
    pending_reqs.push_back(fwd_req(2023, 14, 28));
    pending_reqs.push_back(fwd_req(2023, 15, 31));
    pending_reqs.push_back(fwd_req(2023, 6, 0));
    pending_reqs.push_back(fwd_req(2023, 2, 31));
    pending_reqs.push_back(fwd_req(2000, 2, 29));
    pending_reqs.push_back(fwd_req(1900, 3, 1));
    pending_reqs.push_back(rev_req(0));
    pending_reqs.push_back(rev_req(1));
    pending_reqs.push_back(rev_req(305));
    pending_reqs.push_back(rev_req(306));
    pending_reqs.push_back(rev_req(36524));
    pending_reqs.push_back(rev_req(146096));
    pending_reqs.push_back(rev_req(146097));
    pending_reqs.push_back(rev_req(DN_TOP));
    pending_reqs.push_back(rev_req(4194303));
    wait_drained();

    run_phase('0, 14);
    run_phase('1, 57);
    run_phase(22'($urandom_range(0, 32'(DN_TOP))), 0);
    run_phase(DN_TOP[gdn_pkg::DN_W-1:0], 0);

    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatches++;
    end
    $display("checked %0d results: %0d date-to-number, %0d number-to-date, %0d under minimum",
             results_seen, fwd_count, rev_count, below_count);
    $display("minimum reprogrammed %0d times, including both ends of its range", cfg_writes);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
